// ===== hw/rtl/rsrt_pkg.sv =====
// Package for the in-place MSD radix sorter core.
// Holds payload structs, sequencer states, size constants and the byte select function.
// No dependencies.
package rsrt_pkg;

   localparam int MAX_KEYS_DEF  = 64;
   localparam int KEY_BYTES_DEF = 4;
   localparam int NUM_BUCKETS   = 256;
   localparam int STACK_DEPTH   = 256;
   localparam int BKT_W         = 8;
   localparam int CTR_W         = 9;
   localparam int POS_W         = 4;

   typedef struct packed {
      logic [31:0] key;
      logic        final_key;
   } req_data_type;

   typedef struct packed {
      logic [31:0] sorted_key;
      logic        last_out;
   } rsp_data_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_POP,
      ST_POP_RD,
      ST_CLR,
      ST_HIST,
      ST_HIST_RD,
      ST_HIST_INC,
      ST_PFX,
      ST_PFX_RD,
      ST_PERM_CHK,
      ST_P_INIT,
      ST_P_INIT2,
      ST_P_LOOP,
      ST_P_RD,
      ST_P_DST,
      ST_P_SW1,
      ST_P_SW2,
      ST_ADV,
      ST_ADV_RD,
      ST_ADV_CMP,
      ST_PUSH_INIT,
      ST_PUSH,
      ST_PUSH_RD1,
      ST_PUSH_RD2,
      ST_EMIT,
      ST_EMIT_RD
   } state_type;

   // byte pos counts from the least significant byte; bytes above the key read zero
   function automatic logic [BKT_W-1:0] byte_sel(logic [31:0] k, logic [POS_W-1:0] pos);
      logic [BKT_W-1:0] r;
      unique case (pos)
         4'd0:    r = k[7:0];
         4'd1:    r = k[15:8];
         4'd2:    r = k[23:16];
         4'd3:    r = k[31:24];
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/rsrt_key_mem.sv =====
// Key store of the radix sorter: single port, read-first, registered read data.
// Depends on rsrt_pkg.
module rsrt_key_mem
   import rsrt_pkg::*;
#(
   parameter int MAX_KEYS = MAX_KEYS_DEF,
   localparam int ADDR_W  = $clog2(MAX_KEYS)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [31:0]       wdata,
   output logic [31:0]       rdata
);

   logic [31:0] mem [MAX_KEYS];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/inplace_msd_radix_sorter_core.sv =====
// Top level of the in-place MSD radix sorter (American flag sort over a key batch).
// Depends on rsrt_pkg and rsrt_key_mem.
//
//  channel | ports                          | direction | moves
//  req     | req_valid req_ready req_data   | in        | one key, final_key flag
//  rsp     | rsp_valid rsp_ready rsp_data   | out       | one sorted key, last_out flag
//
// A non-final key is stored in the key store. A final key runs the sort, one range
// at a time: clear the counts, build the histogram, run the prefix sweep,
// permute the keys by swaps, then push the buckets as new ranges. Output then
// streams one key per cycle while rsp is not stalled. Reset is synchronous and
// clears control only.
// A stalled rsp holds the stream; req is ready only when the sequencer is idle.
module inplace_msd_radix_sorter_core
   import rsrt_pkg::*;
#(
   parameter int MAX_KEYS  = MAX_KEYS_DEF,
   parameter int KEY_BYTES = KEY_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   localparam int KIDX_W = $clog2(MAX_KEYS + 1);
   localparam int KADR_W = $clog2(MAX_KEYS);
   localparam int BI_W   = $clog2(KEY_BYTES + 1);
   localparam int STK_W  = 2 * KIDX_W + BI_W;
   localparam int SP_W   = $clog2(STACK_DEPTH + 1);

   state_type          state_ff, state_in;
   logic [KIDX_W-1:0]  cnt_ff, cnt_in;
   logic [KIDX_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [BI_W-1:0]    bi_ff, bi_in;
   logic [CTR_W-1:0]   idx_ff, idx_in;
   logic [KIDX_W-1:0]  total_ff, total_in;
   logic [CTR_W-1:0]   number_ff, number_in;
   logic [BKT_W-1:0]   cur_ff, cur_in;
   logic [CTR_W-1:0]   cur_pos_ff, cur_pos_in;
   logic [KIDX_W-1:0]  it_ff, it_in;
   logic [KIDX_W-1:0]  block_end_ff, block_end_in;
   logic [KIDX_W-1:0]  begin_ff, begin_in;
   logic [KIDX_W-1:0]  dst_ff, dst_in;
   logic [BKT_W-1:0]   bsel_ff, bsel_in;
   logic [31:0]        keya_ff, keya_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff, rsp_data_in;

   logic               key_we;
   logic [KADR_W-1:0]  key_addr;
   logic [31:0]        key_wd, key_rd;

   logic [KIDX_W-1:0]  cnt_mem [NUM_BUCKETS];
   logic [KIDX_W-1:0]  end_mem [NUM_BUCKETS];
   logic [BKT_W-1:0]   prs_mem [NUM_BUCKETS];
   logic [STK_W-1:0]   stk_mem [STACK_DEPTH];

   logic               cnt_we, end_we, prs_we, stk_we;
   logic [BKT_W-1:0]   cnt_wa, cnt_ra, end_wa, end_ra, prs_wa, prs_ra, stk_wa, stk_ra;
   logic [KIDX_W-1:0]  cnt_wd, end_wd;
   logic [BKT_W-1:0]   prs_wd;
   logic [STK_W-1:0]   stk_wd;
   logic [KIDX_W-1:0]  cnt_rd_ff, end_rd_ff;
   logic [BKT_W-1:0]   prs_rd_ff;
   logic [STK_W-1:0]   stk_rd_ff;

   logic [POS_W-1:0]   pos;
   logic [BKT_W-1:0]   kbyte;
   logic [KIDX_W-1:0]  n_new;
   logic [KIDX_W-1:0]  it_nx;
   logic [CTR_W-1:0]   cp_nx;
   logic               slot_free;

   rsrt_key_mem #(
      .MAX_KEYS(MAX_KEYS)
   ) u_key_mem (
      .clock (clock),
      .we    (key_we),
      .addr  (key_addr),
      .wdata (key_wd),
      .rdata (key_rd)
   );

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd_ff <= cnt_mem[cnt_ra];
      if (end_we) begin
         end_mem[end_wa] <= end_wd;
      end
      end_rd_ff <= end_mem[end_ra];
      if (prs_we) begin
         prs_mem[prs_wa] <= prs_wd;
      end
      prs_rd_ff <= prs_mem[prs_ra];
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stk_mem[stk_ra];
   end

   assign pos       = POS_W'(KEY_BYTES - 1) - POS_W'(bi_ff);
   assign kbyte     = byte_sel(key_rd, pos);
   assign n_new     = (cnt_ff < KIDX_W'(MAX_KEYS)) ? cnt_ff + 1'b1 : cnt_ff;
   assign it_nx     = it_ff + 1'b1;
   assign cp_nx     = cur_pos_ff + 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      bi_in        = bi_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      number_in    = number_ff;
      cur_in       = cur_ff;
      cur_pos_in   = cur_pos_ff;
      it_in        = it_ff;
      block_end_in = block_end_ff;
      begin_in     = begin_ff;
      dst_in       = dst_ff;
      bsel_in      = bsel_ff;
      keya_in      = keya_ff;
      sp_in        = sp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      key_we   = 1'b0;
      key_addr = '0;
      key_wd   = keya_ff;
      cnt_we   = 1'b0;
      cnt_wa   = bsel_ff;
      cnt_wd   = '0;
      cnt_ra   = bsel_ff;
      end_we   = 1'b0;
      end_wa   = idx_ff[BKT_W-1:0];
      end_wd   = '0;
      end_ra   = cur_ff;
      prs_we   = 1'b0;
      prs_wa   = number_ff[BKT_W-1:0];
      prs_wd   = idx_ff[BKT_W-1:0];
      prs_ra   = idx_ff[BKT_W-1:0];
      stk_we   = 1'b0;
      stk_wa   = sp_ff[BKT_W-1:0];
      stk_wd   = '0;
      stk_ra   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            key_addr = cnt_ff[KADR_W-1:0];
            key_wd   = req_data.key;
            if (req_valid) begin
               if (cnt_ff < KIDX_W'(MAX_KEYS)) begin
                  key_we = 1'b1;
               end
               cnt_in = n_new;
               if (req_data.final_key) begin
                  if (n_new > KIDX_W'(1)) begin
                     stk_we   = 1'b1;
                     stk_wa   = '0;
                     stk_wd   = {KIDX_W'(0), n_new, BI_W'(0)};
                     sp_in    = SP_W'(1);
                     state_in = ST_POP;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               sp_in    = sp_ff - 1'b1;
               stk_ra   = BKT_W'(sp_ff - 1'b1);
               state_in = ST_POP_RD;
            end
         end
         ST_POP_RD: begin
            {lo_in, hi_in, bi_in} = stk_rd_ff;
            idx_in   = '0;
            state_in = ST_CLR;
         end
         ST_CLR: begin
            cnt_we = 1'b1;
            cnt_wa = idx_ff[BKT_W-1:0];
            cnt_wd = '0;
            idx_in = idx_ff + 1'b1;
            if (idx_ff[BKT_W-1:0] == BKT_W'(NUM_BUCKETS - 1)) begin
               idx_in   = CTR_W'(lo_ff);
               state_in = ST_HIST;
            end
         end
         ST_HIST: begin
            key_addr = idx_ff[KADR_W-1:0];
            if (idx_ff < CTR_W'(hi_ff) && idx_ff < CTR_W'(MAX_KEYS)) begin
               state_in = ST_HIST_RD;
            end else begin
               idx_in    = '0;
               total_in  = lo_ff;
               number_in = '0;
               state_in  = ST_PFX;
            end
         end
         ST_HIST_RD: begin
            cnt_ra   = kbyte;
            bsel_in  = kbyte;
            state_in = ST_HIST_INC;
         end
         ST_HIST_INC: begin
            cnt_we   = 1'b1;
            cnt_wa   = bsel_ff;
            cnt_wd   = cnt_rd_ff + 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = ST_HIST;
         end
         ST_PFX: begin
            cnt_ra   = idx_ff[BKT_W-1:0];
            state_in = ST_PFX_RD;
         end
         ST_PFX_RD: begin
            cnt_we   = 1'b1;
            cnt_wa   = idx_ff[BKT_W-1:0];
            cnt_wd   = total_ff;
            end_we   = 1'b1;
            end_wa   = idx_ff[BKT_W-1:0];
            end_wd   = total_ff + cnt_rd_ff;
            total_in = total_ff + cnt_rd_ff;
            if (cnt_rd_ff != '0) begin
               prs_we    = 1'b1;
               number_in = number_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff[BKT_W-1:0] == BKT_W'(NUM_BUCKETS - 1)) begin
               state_in = ST_PERM_CHK;
            end else begin
               state_in = ST_PFX;
            end
         end
         ST_PERM_CHK: begin
            prs_ra = '0;
            if (number_ff > CTR_W'(1)) begin
               state_in = ST_P_INIT;
            end else begin
               state_in = ST_PUSH_INIT;
            end
         end
         ST_P_INIT: begin
            cur_in     = prs_rd_ff;
            cur_pos_in = '0;
            it_in      = lo_ff;
            end_ra     = prs_rd_ff;
            state_in   = ST_P_INIT2;
         end
         ST_P_INIT2: begin
            block_end_in = end_rd_ff;
            state_in     = ST_P_LOOP;
         end
         ST_P_LOOP: begin
            key_addr = it_ff[KADR_W-1:0];
            if (it_ff >= KIDX_W'(MAX_KEYS)) begin
               state_in = ST_PUSH_INIT;
            end else begin
               state_in = ST_P_RD;
            end
         end
         ST_P_RD: begin
            key_addr = it_ff[KADR_W-1:0];
            if (kbyte == cur_ff) begin
               it_in = it_nx;
               if (it_nx == hi_ff - 1'b1) begin
                  state_in = ST_PUSH_INIT;
               end else if (it_nx == block_end_ff) begin
                  state_in = ST_ADV;
               end else begin
                  state_in = ST_P_LOOP;
               end
            end else begin
               cnt_ra   = kbyte;
               bsel_in  = kbyte;
               keya_in  = key_rd;
               state_in = ST_P_DST;
            end
         end
         ST_P_DST: begin
            cnt_we   = 1'b1;
            cnt_wa   = bsel_ff;
            cnt_wd   = cnt_rd_ff + 1'b1;
            dst_in   = cnt_rd_ff;
            key_addr = cnt_rd_ff[KADR_W-1:0];
            if (cnt_rd_ff >= hi_ff) begin
               state_in = ST_PUSH_INIT;
            end else begin
               state_in = ST_P_SW1;
            end
         end
         ST_P_SW1: begin
            key_we   = 1'b1;
            key_addr = dst_ff[KADR_W-1:0];
            key_wd   = keya_ff;
            keya_in  = key_rd;
            state_in = ST_P_SW2;
         end
         ST_P_SW2: begin
            key_we   = 1'b1;
            key_addr = it_ff[KADR_W-1:0];
            key_wd   = keya_ff;
            state_in = ST_P_LOOP;
         end
         ST_ADV: begin
            cur_pos_in = cp_nx;
            prs_ra     = cp_nx[BKT_W-1:0];
            if (cp_nx >= number_ff - 1'b1) begin
               state_in = ST_PUSH_INIT;
            end else begin
               state_in = ST_ADV_RD;
            end
         end
         ST_ADV_RD: begin
            cur_in   = prs_rd_ff;
            cnt_ra   = prs_rd_ff;
            end_ra   = prs_rd_ff;
            state_in = ST_ADV_CMP;
         end
         ST_ADV_CMP: begin
            if (cnt_rd_ff != end_rd_ff) begin
               it_in        = cnt_rd_ff;
               block_end_in = end_rd_ff;
               state_in     = ST_P_LOOP;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_PUSH_INIT: begin
            idx_in   = '0;
            begin_in = lo_ff;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            prs_ra = idx_ff[BKT_W-1:0];
            if (idx_ff == number_ff) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_PUSH_RD1;
            end
         end
         ST_PUSH_RD1: begin
            end_ra   = prs_rd_ff;
            state_in = ST_PUSH_RD2;
         end
         ST_PUSH_RD2: begin
            if ((KIDX_W + 1)'(end_rd_ff) > (KIDX_W + 1)'(begin_ff) + 1'b1
                && (BI_W + 1)'(bi_ff) + 1'b1 < (BI_W + 1)'(KEY_BYTES)
                && sp_ff < SP_W'(STACK_DEPTH)) begin
               stk_we = 1'b1;
               stk_wd = {begin_ff, end_rd_ff, BI_W'(bi_ff + 1'b1)};
               sp_in  = sp_ff + 1'b1;
            end
            begin_in = end_rd_ff;
            idx_in   = idx_ff + 1'b1;
            state_in = ST_PUSH;
         end
         ST_EMIT: begin
            idx_in   = '0;
            key_addr = '0;
            state_in = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            key_addr = idx_ff[KADR_W-1:0];
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.sorted_key = key_rd;
               rsp_data_in.last_out   = (idx_ff + 1'b1 == CTR_W'(cnt_ff));
               idx_in                 = idx_ff + 1'b1;
               key_addr               = KADR_W'(idx_ff + 1'b1);
               if (idx_ff + 1'b1 == CTR_W'(cnt_ff)) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      bi_ff        <= bi_in;
      idx_ff       <= idx_in;
      total_ff     <= total_in;
      number_ff    <= number_in;
      cur_ff       <= cur_in;
      cur_pos_ff   <= cur_pos_in;
      it_ff        <= it_in;
      block_end_ff <= block_end_in;
      begin_ff     <= begin_in;
      dst_ff       <= dst_in;
      bsel_ff      <= bsel_in;
      keya_ff      <= keya_in;
      rsp_data_ff  <= rsp_data_in;
   end

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("range stack pointer beyond depth");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= KIDX_W'(MAX_KEYS))
      else $error("key count beyond batch size");

   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD && rsp_valid_ff && !rsp_ready) |=> $stable(idx_ff))
      else $error("emit index advanced while output stalled");

   a_swap_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_SW1) |-> (dst_ff < hi_ff && it_ff < hi_ff))
      else $error("swap address outside current range");

endmodule
